@@ hw/rtl/qcms_pkg.sv @@
package qcms_pkg;

  // Default code geometry
  localparam int BLOCK_BITS_DEF = 4801;
  localparam int NUM_BLOCKS_DEF = 2;
  localparam int KEY_WEIGHT_DEF = 45;

  // Fixed field widths of the command and result ports
  localparam int FUNC_W     = 3;
  localparam int BLOCK_W    = 1;
  localparam int SLOT_W     = 6;
  localparam int KEYPOS_W   = 13;
  localparam int BYTE_IDX_W = 10;
  localparam int BYTE_W     = 8;
  localparam int BIT_POS_W  = 14;
  localparam int UPC_W      = 6;
  localparam int UPC_MAX    = 63;

  // Per-cycle commands from the sequencer to the syndrome engine
  typedef struct packed {
    logic issue;    // start one key lookup / syndrome access
    logic test;     // access counts a set bit instead of flipping it
    logic key_we;   // write one key position
    logic clr_we;   // zero one syndrome row
    logic syn_re;   // read one syndrome row for the byte output
    logic cnt_clr;  // restart the unsatisfied-check counter
  } qcms_ctrl_t;

endpackage

@@ hw/rtl/qcms_div.sv @@
// Division by a constant through repeated compare and subtract, one subtraction per cycle.
module qcms_div import qcms_pkg::*; #(
  parameter int DIVISOR = BLOCK_BITS_DEF,
  parameter int N_W     = BIT_POS_W,
  parameter int R_W     = $clog2(BLOCK_BITS_DEF)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o,
  output logic [R_W-1:0] rem_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [N_W-1:0]  r_q, r_d;
  logic [N_W-1:0]  q_q, q_d;
  logic            ge;

  assign ge = (32'(r_q) >= DIVISOR);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    r_d    = r_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      r_d    = dividend_i;
      q_d    = '0;
    end else if (busy_q) begin
      if (ge) begin
        r_d = r_q - N_W'(DIVISOR);
        q_d = q_q + 1'b1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = R_W'(r_q);

endmodule

@@ hw/rtl/qcms_engine.sv @@
// Key store, syndrome RAM and the three-stage lookup / read-modify-write pipe.
module qcms_engine import qcms_pkg::*; #(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int KEY_WEIGHT = KEY_WEIGHT_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  qcms_ctrl_t                                    ctrl_i,
  input  logic [$clog2(NUM_BLOCKS*KEY_WEIGHT)-1:0]      key_addr_i,
  input  logic [$clog2(BLOCK_BITS)-1:0]                 key_wdata_i,
  input  logic [$clog2(BLOCK_BITS)-1:0]                 base_pos_i,
  input  logic [(((BLOCK_BITS+7)/8) > 1 ? $clog2((BLOCK_BITS+7)/8) : 1)-1:0] row_i,
  output logic                                          idle_o,
  output logic [$clog2(KEY_WEIGHT+1)-1:0]               cnt_o,
  output logic [BYTE_W-1:0]                             syn_byte_o
);

  localparam int PW    = $clog2(BLOCK_BITS);
  localparam int KDEP  = NUM_BLOCKS * KEY_WEIGHT;
  localparam int ROWS  = (BLOCK_BITS + 7) / 8;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(KEY_WEIGHT + 1);

  logic [PW-1:0]     key_mem [KDEP];
  logic [BYTE_W-1:0] syn_mem [ROWS];

  // stage 1: key position read back
  logic              s1_vld_q, s1_test_q;
  logic [PW-1:0]     s1_base_q, key_rd_q;
  // stage 2: syndrome row read back
  logic              s2_vld_q, s2_test_q;
  logic [RA_W-1:0]   s2_row_q;
  logic [2:0]        s2_bit_q;
  logic [BYTE_W-1:0] syn_rd_q;
  // last write, forwarded when the next access hits the same row
  logic              wr_vld_q;
  logic [RA_W-1:0]   wr_row_q;
  logic [BYTE_W-1:0] wr_data_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [PW:0]       diff, wrap;
  logic [PW-1:0]     pos;
  logic [RA_W-1:0]   pos_row, rd_row;
  logic [BYTE_W-1:0] cur, wdata;
  logic              flip_we, hit;

  // (base - p) mod BLOCK_BITS
  assign diff    = {1'b0, s1_base_q} - {1'b0, key_rd_q};
  assign wrap    = diff + (PW+1)'(BLOCK_BITS);
  assign pos     = (s1_base_q >= key_rd_q) ? PW'(diff) : PW'(wrap);
  assign pos_row = RA_W'(pos >> 3);
  assign rd_row  = s1_vld_q ? pos_row : row_i;

  assign cur     = (wr_vld_q && (wr_row_q == s2_row_q)) ? wr_data_q : syn_rd_q;
  assign wdata   = cur ^ (BYTE_W'(1) << s2_bit_q);
  assign flip_we = s2_vld_q && !s2_test_q;
  assign hit     = cur[s2_bit_q];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_we) begin
      key_mem[key_addr_i] <= key_wdata_i;
    end
    key_rd_q <= key_mem[key_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (flip_we) begin
      syn_mem[s2_row_q] <= wdata;
    end else if (ctrl_i.clr_we) begin
      syn_mem[row_i] <= '0;
    end
    syn_rd_q <= syn_mem[rd_row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      s1_vld_q <= ctrl_i.issue;
      s2_vld_q <= s1_vld_q;
      wr_vld_q <= flip_we;
      if (ctrl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (s2_vld_q && s2_test_q && hit) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_test_q <= ctrl_i.test;
    s1_base_q <= base_pos_i;
    s2_test_q <= s1_test_q;
    s2_row_q  <= pos_row;
    s2_bit_q  <= pos[2:0];
    wr_row_q  <= s2_row_q;
    wr_data_q <= wdata;
  end

  assign idle_o     = !s1_vld_q && !s2_vld_q;
  assign cnt_o      = cnt_q;
  assign syn_byte_o = syn_rd_q;

`ifndef NO_ASSERTIONS
  a_no_wr_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flip_we && ctrl_i.clr_we))
    else $error("flip write collides with clear write");

  a_byte_rd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.syn_re |-> (!s1_vld_q && !s2_vld_q))
    else $error("byte read while pipe is busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= KEY_WEIGHT)
    else $error("check counter beyond key weight");
`endif

endmodule

@@ hw/rtl/qc_mdpc_syndrome_and_upc_top.sv @@
// One command at a time; busy is registered, high once start is taken and through the single
// result strobe, so a new command can follow when busy drops. Key load divides key_position by
// BLOCK_BITS and stores the remainder; clear zeroes every syndrome row; accumulate issues one
// syndrome RMW per cycle for each key position of each set bit; upc divides bit_position by
// BLOCK_BITS, tests KEY_WEIGHT positions or ends early past the codeword; read gives zero past the
// block. Reset: syndrome RAM swept to zero row by row, busy high; no result stall.
module qc_mdpc_syndrome_and_upc_top import qcms_pkg::*; #(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int KEY_WEIGHT = KEY_WEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [BLOCK_W-1:0]    block_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [KEYPOS_W-1:0]   key_position_i,
  input  logic [BYTE_IDX_W-1:0] byte_index_i,
  input  logic [BYTE_W-1:0]     code_byte_i,
  input  logic [BIT_POS_W-1:0]  bit_position_i,
  output logic                  done_o,
  output logic [UPC_W-1:0]      upc_count_o,
  output logic [BYTE_W-1:0]     syndrome_byte_o
);

  localparam int PW    = $clog2(BLOCK_BITS);
  localparam int KA_W  = $clog2(NUM_BLOCKS * KEY_WEIGHT);
  localparam int ROWS  = (BLOCK_BITS + 7) / 8;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(KEY_WEIGHT + 1);
  localparam int KC_W  = (KEY_WEIGHT > 1) ? $clog2(KEY_WEIGHT) : 1;
  localparam int BLK_W = $clog2(NUM_BLOCKS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_KEY = 3'd0,
    FUNC_CLEAR    = 3'd1,
    FUNC_ACCUM    = 3'd2,
    FUNC_UPC      = 3'd3,
    FUNC_READ     = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DIV, ST_CLR, ST_ACC, ST_UPC, ST_DRAIN, ST_RDREQ, ST_RDWAIT,
    ST_RESP
  } st_e;

  st_e                   state_q, state_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [BYTE_IDX_W-1:0] bidx_q, bidx_d;
  logic [BYTE_W-1:0]     code_q, code_d;
  logic [RA_W-1:0]       row_q, row_d;
  logic [2:0]            b_q, b_d;
  logic [KC_W-1:0]       k_q, k_d;
  logic [KA_W-1:0]       base_q, base_d;
  logic [PW-1:0]         idx_q, idx_d;
  logic [UPC_W-1:0]      res_upc_q, res_upc_d;
  logic [BYTE_W-1:0]     res_byte_q, res_byte_d;

  qcms_ctrl_t            ctrl;
  logic [KA_W-1:0]       key_addr;
  logic [PW-1:0]         base_pos;
  logic [RA_W-1:0]       eng_row;
  logic                  eng_idle;
  logic [CNT_W-1:0]      eng_cnt;
  logic [BYTE_W-1:0]     eng_byte;

  logic                  div_start, div_done;
  logic [BIT_POS_W-1:0]  dividend, quot;
  logic [PW-1:0]         rem;

  logic [12:0]           acc_j;
  logic                  acc_on;
  logic [UPC_W-1:0]      upc_sat;

  assign acc_j   = {bidx_q, b_q};
  assign acc_on  = code_q[b_q] && (32'(acc_j) < BLOCK_BITS);
  assign upc_sat = (32'(eng_cnt) > UPC_MAX) ? UPC_W'(UPC_MAX) : UPC_W'(eng_cnt);

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    slot_d     = slot_q;
    bidx_d     = bidx_q;
    code_d     = code_q;
    row_d      = row_q;
    b_d        = b_q;
    k_d        = k_q;
    base_d     = base_q;
    idx_d      = idx_q;
    res_upc_d  = res_upc_q;
    res_byte_d = res_byte_q;
    ctrl       = '0;
    key_addr   = base_q + KA_W'(k_q);
    base_pos   = idx_q;
    eng_row    = row_q;
    div_start  = 1'b0;
    dividend   = bit_position_i;

    unique case (state_q)
      ST_INIT, ST_CLR: begin
        ctrl.clr_we = 1'b1;
        if (row_q == RA_W'(ROWS - 1)) begin
          row_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          func_d     = func_i;
          slot_d     = slot_i;
          bidx_d     = byte_index_i;
          code_d     = code_byte_i;
          base_d     = KA_W'(block_i) * KA_W'(KEY_WEIGHT);
          b_d        = '0;
          k_d        = '0;
          row_d      = '0;
          res_upc_d  = '0;
          res_byte_d = '0;
          state_d    = ST_RESP;
          unique case (func_i)
            FUNC_LOAD_KEY: begin
              if ((32'(block_i) < NUM_BLOCKS) && (32'(slot_i) < KEY_WEIGHT)) begin
                div_start = 1'b1;
                dividend  = BIT_POS_W'(key_position_i);
                state_d   = ST_DIV;
              end
            end
            FUNC_CLEAR: state_d = ST_CLR;
            FUNC_ACCUM: begin
              if (32'(block_i) < NUM_BLOCKS) begin
                state_d = ST_ACC;
              end
            end
            FUNC_UPC: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            FUNC_READ: begin
              if (32'(byte_index_i) < ROWS) begin
                state_d = ST_RDREQ;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (func_q == FUNC_LOAD_KEY) begin
            ctrl.key_we = 1'b1;
            key_addr    = base_q + KA_W'(slot_q);
            state_d     = ST_RESP;
          end else if (32'(quot) >= NUM_BLOCKS) begin
            state_d = ST_RESP;
          end else begin
            base_d       = KA_W'(quot[BLK_W-1:0]) * KA_W'(KEY_WEIGHT);
            idx_d        = rem;
            k_d          = '0;
            ctrl.cnt_clr = 1'b1;
            state_d      = ST_UPC;
          end
        end
      end
      ST_ACC: begin
        base_pos = PW'(acc_j);
        if (acc_on) begin
          ctrl.issue = 1'b1;
        end
        if (acc_on && (k_q != KC_W'(KEY_WEIGHT - 1))) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          b_d = b_q + 1'b1;
          if (b_q == 3'd7) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_UPC: begin
        ctrl.issue = 1'b1;
        ctrl.test  = 1'b1;
        if (k_q == KC_W'(KEY_WEIGHT - 1)) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (eng_idle) begin
          if (func_q == FUNC_UPC) begin
            res_upc_d = upc_sat;
          end
          state_d = ST_RESP;
        end
      end
      ST_RDREQ: begin
        ctrl.syn_re = 1'b1;
        eng_row     = RA_W'(bidx_q);
        state_d     = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        res_byte_d = eng_byte;
        state_d    = ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      row_q      <= '0;
      b_q        <= '0;
      k_q        <= '0;
      res_upc_q  <= '0;
      res_byte_q <= '0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      b_q        <= b_d;
      k_q        <= k_d;
      res_upc_q  <= res_upc_d;
      res_byte_q <= res_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    slot_q <= slot_d;
    bidx_q <= bidx_d;
    code_q <= code_d;
    base_q <= base_d;
    idx_q  <= idx_d;
  end

  qcms_div #(
    .DIVISOR (BLOCK_BITS),
    .N_W     (BIT_POS_W),
    .R_W     (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  qcms_engine #(
    .BLOCK_BITS (BLOCK_BITS),
    .NUM_BLOCKS (NUM_BLOCKS),
    .KEY_WEIGHT (KEY_WEIGHT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .key_addr_i  (key_addr),
    .key_wdata_i (rem),
    .base_pos_i  (base_pos),
    .row_i       (eng_row),
    .idle_o      (eng_idle),
    .cnt_o       (eng_cnt),
    .syn_byte_o  (eng_byte)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_RESP);
  assign upc_count_o     = res_upc_q;
  assign syndrome_byte_o = res_byte_q;

`ifndef NO_ASSERTIONS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_upc_only_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (func_q != FUNC_UPC)) |-> (upc_count_o == '0))
    else $error("check count reported for another command");

  a_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> eng_idle)
    else $error("engine pipe still busy while idle");
`endif

endmodule
